>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL files of the tremolo block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define AST_HOLD(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// A condition that forces another one in the following cycle.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_HOLD(lbl, clk, rst_n, prop)
`define AST_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/stap_pkg.sv
// Package with widths, constants, types and helper functions of the tremolo block.
package stap_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int PHASE_BITS  = 32;
    // Sine table depth; must be a power of two.
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int TBL_BITS = $clog2(SINE_TABLE_DEPTH);

    localparam int DATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int STEP_BITS = 24;
    localparam int CTRL_BITS = 16;
    localparam int CFG_BITS  = 24;
    localparam int Q15_ONE   = 32768;

    // Turn position of the sine approximation and the widths of its division.
    localparam int TURN_BITS = 16;
    localparam int H_BITS    = TURN_BITS - 1;
    localparam int Q_BITS    = 2 * TURN_BITS - 3;
    localparam int DEN_BITS  = 35;
    localparam int NUM_BITS  = 50;
    localparam int QUO_BITS  = 16;
    localparam int CNT_BITS  = $clog2(QUO_BITS);
    localparam logic [DEN_BITS-1:0] DEN_BASE = DEN_BITS'(64'd5 << 32);

    // Shared multiplier operands and product.
    localparam int MUL_A_BITS = (SAMPLE_BITS + 1 > 17) ? SAMPLE_BITS + 1 : 17;
    localparam int MUL_B_BITS = 18;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
    localparam int ACC_BITS   = PROD_BITS + 1;

    localparam logic signed [ACC_BITS-1:0] ACC_SMAX =
        ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_BITS-1:0] ACC_SMIN = -ACC_SMAX - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] ACC_HALF15 = ACC_BITS'(16384);

    typedef enum logic [1:0] {
        CFG_PHASE_STEP = 2'd0,
        CFG_DEPTH      = 2'd1,
        CFG_WET_MIX    = 2'd2,
        CFG_AUTO_PAN   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                start;
        logic [NUM_BITS-1:0] num;
        logic [DEN_BITS-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [QUO_BITS-1:0] quo;
    } t_div_rsp;

    // Round half up, then shift right by 15.
    function automatic logic signed [ACC_BITS-1:0] rnd15(
        input logic signed [ACC_BITS-1:0] v
    );
        return (v + ACC_HALF15) >>> 15;
    endfunction

    // Clamp to the sample range.
    function automatic logic signed [SAMPLE_BITS-1:0] sat(
        input logic signed [ACC_BITS-1:0] v
    );
        if (v > ACC_SMAX) begin
            return SAMPLE_BITS'(ACC_SMAX);
        end else if (v < ACC_SMIN) begin
            return SAMPLE_BITS'(ACC_SMIN);
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

>>> hw/rtl/stap_div.sv
// Restoring divider, one quotient bit per cycle, for the sine approximation.
module stap_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stap_pkg::t_div_req i_req,
    output stap_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [stap_pkg::CNT_BITS-1:0] r_cnt;
    logic [stap_pkg::DEN_BITS-1:0] r_rem;
    logic [stap_pkg::DEN_BITS-1:0] r_den;
    logic [stap_pkg::QUO_BITS-1:0] r_low;
    logic [stap_pkg::QUO_BITS-1:0] r_quo;

    logic [stap_pkg::DEN_BITS:0]   w_shift;
    logic [stap_pkg::DEN_BITS+1:0] w_trial;
    logic                          w_qbit;

    // The numerator is below den * 2^16, so its upper part already fits the remainder.
    assign w_shift = {r_rem, r_low[stap_pkg::QUO_BITS-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_den};
    assign w_qbit  = !w_trial[stap_pkg::DEN_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= stap_pkg::DEN_BITS'(i_req.num[stap_pkg::NUM_BITS-1:stap_pkg::QUO_BITS]);
                r_low  <= i_req.num[stap_pkg::QUO_BITS-1:0];
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem <= w_qbit ? w_trial[stap_pkg::DEN_BITS-1:0]
                                : w_shift[stap_pkg::DEN_BITS-1:0];
                r_low <= {r_low[stap_pkg::QUO_BITS-2:0], 1'b0};
                r_quo <= {r_quo[stap_pkg::QUO_BITS-2:0], w_qbit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == stap_pkg::CNT_BITS'(stap_pkg::QUO_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

>>> hw/rtl/stereo_tremolo_autopan.sv
// Stereo tremolo with auto-pan: sequencer around one shared multiplier and a divider.
//
// Usage: stereo sample pairs enter on the slave stream (tdata holds left_in in
// the low bits, right_in above it) and leave on the master stream with the
// same packing. The LFO phase advances by phase_step for every item.
// Configuration must be written through i_cfg_we / i_cfg_index / i_cfg_data
// only while the block is idle; the block itself does not enforce this. Indices:
// 0 phase_step, 1 depth, 2 wet_mix, 3 auto_pan. A new item is accepted only
// after the result of the last one has been loaded; the bit-serial divider
// evaluates the sine approximation, then eight gain and mix products are
// issued one per cycle on the shared multiplier. o_s_axis_tready is high
// only while the sequencer is idle.
// A finished result sits in an output register, so the next item may be taken
// while it waits; if the receiver stalls long enough that a second result is
// ready, the sequencer holds it until the register frees.
// Reset (synchronous, active low) zeroes the LFO phase, restores the default
// register values and empties the output register.
`include "assert_macros.svh"

module stereo_tremolo_autopan (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // Fields from bit 0: left_in, right_in.
    input  logic [stap_pkg::DATA_BITS-1:0] i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // Fields from bit 0: left_out, right_out.
    output logic [stap_pkg::DATA_BITS-1:0] o_m_axis_tdata,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [stap_pkg::CFG_BITS-1:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_DEN, S_DIV, S_GL, S_GR, S_WL, S_WR,
        S_ML0, S_ML1, S_MR0, S_MR1, S_FIN
    } t_state;

    t_state r_state;

    logic [stap_pkg::STEP_BITS-1:0]  r_phase_step;
    logic [stap_pkg::CTRL_BITS-1:0]  r_depth;
    logic [stap_pkg::CTRL_BITS-1:0]  r_wet_mix;
    logic                            r_auto_pan;
    logic [stap_pkg::PHASE_BITS-1:0] r_phase;

    logic signed [stap_pkg::SAMPLE_BITS-1:0] r_left;
    logic signed [stap_pkg::SAMPLE_BITS-1:0] r_right;
    logic                                    r_neg;
    logic signed [stap_pkg::QUO_BITS:0]      r_sine;
    logic [stap_pkg::CTRL_BITS-1:0]          r_gl;
    logic [stap_pkg::CTRL_BITS-1:0]          r_gr;
    logic signed [stap_pkg::SAMPLE_BITS-1:0] r_wl;
    logic signed [stap_pkg::SAMPLE_BITS-1:0] r_wr;
    logic signed [stap_pkg::SAMPLE_BITS-1:0] r_mix_l;
    logic signed [stap_pkg::PROD_BITS-1:0]   r_prod;
    logic signed [stap_pkg::PROD_BITS-1:0]   r_acc;

    logic                                    r_m_valid;
    logic signed [stap_pkg::SAMPLE_BITS-1:0] r_out_l;
    logic signed [stap_pkg::SAMPLE_BITS-1:0] r_out_r;

    stap_pkg::t_div_req w_div_req;
    stap_pkg::t_div_rsp w_div_rsp;

    logic [stap_pkg::TBL_BITS-1:0]          w_idx;
    logic [stap_pkg::TURN_BITS-1:0]         w_turn;
    logic [stap_pkg::H_BITS-1:0]            w_h;
    logic [stap_pkg::TURN_BITS-1:0]         w_hc;
    logic [stap_pkg::Q_BITS-1:0]            w_q;
    logic [stap_pkg::DEN_BITS-1:0]          w_den;
    logic [stap_pkg::CTRL_BITS-1:0]         w_dep;
    logic [stap_pkg::CTRL_BITS-1:0]         w_mix;
    logic [stap_pkg::CTRL_BITS-1:0]         w_mix_c;
    logic signed [stap_pkg::PROD_BITS-1:0]  w_rnd16;
    logic [stap_pkg::CTRL_BITS-1:0]         w_gain;
    logic signed [stap_pkg::ACC_BITS-1:0]   w_sum;
    logic signed [stap_pkg::SAMPLE_BITS-1:0] w_wet;
    logic signed [stap_pkg::SAMPLE_BITS-1:0] w_mixed;
    logic signed [stap_pkg::MUL_A_BITS-1:0] w_mul_a;
    logic signed [stap_pkg::MUL_B_BITS-1:0] w_mul_b;
    logic signed [stap_pkg::PROD_BITS-1:0]  w_mul_p;
    logic                                   w_accept;
    logic                                   w_out_free;

    localparam logic signed [stap_pkg::MUL_B_BITS-1:0] B_ONE =
        stap_pkg::MUL_B_BITS'(stap_pkg::Q15_ONE);
    localparam logic signed [stap_pkg::PROD_BITS-1:0] P_HALF16 =
        stap_pkg::PROD_BITS'(32768);
    localparam logic [stap_pkg::CTRL_BITS-1:0] C_ONE =
        stap_pkg::CTRL_BITS'(stap_pkg::Q15_ONE);

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_m_valid || i_m_axis_tready;

    // Table index and turn position of the current phase.
    assign w_idx  = r_phase[stap_pkg::PHASE_BITS-1 -: stap_pkg::TBL_BITS];
    assign w_turn = {w_idx, {(stap_pkg::TURN_BITS - stap_pkg::TBL_BITS){1'b0}}};
    assign w_h    = w_turn[stap_pkg::H_BITS-1:0];
    assign w_hc   = C_ONE - {1'b0, w_h};

    // Denominator and rounded numerator of the rational sine.
    assign w_q   = r_prod[stap_pkg::Q_BITS-1:0];
    assign w_den = stap_pkg::DEN_BASE - stap_pkg::DEN_BITS'({w_q, 4'b0000});
    assign w_div_req.start = (r_state == S_DEN);
    assign w_div_req.num   = stap_pkg::NUM_BITS'({w_q, 21'd0})
                           + stap_pkg::NUM_BITS'(w_den[stap_pkg::DEN_BITS-1:1]);
    assign w_div_req.den   = w_den;

    assign w_dep   = (r_depth > C_ONE) ? C_ONE : r_depth;
    assign w_mix   = (r_wet_mix > C_ONE) ? C_ONE : r_wet_mix;
    assign w_mix_c = C_ONE - w_mix;

    // The rounded depth product never exceeds one, so the gain stays in 0..1.
    assign w_rnd16 = (r_prod + P_HALF16) >>> 16;
    assign w_gain  = C_ONE - w_rnd16[stap_pkg::CTRL_BITS-1:0];
    assign w_sum   = stap_pkg::ACC_BITS'(r_acc) + stap_pkg::ACC_BITS'(r_prod);
    assign w_wet   = stap_pkg::sat(stap_pkg::rnd15(stap_pkg::ACC_BITS'(r_prod)));
    assign w_mixed = stap_pkg::sat(stap_pkg::rnd15(w_sum));

    // Operand selection of the shared multiplier; the product is used in the next state.
    always_comb begin
        w_mul_a = $signed(stap_pkg::MUL_A_BITS'(w_h));
        w_mul_b = $signed(stap_pkg::MUL_B_BITS'(w_hc));
        case (r_state)
            S_GL: begin
                w_mul_a = $signed(stap_pkg::MUL_A_BITS'(w_dep));
                w_mul_b = B_ONE + stap_pkg::MUL_B_BITS'(r_sine);
            end
            S_GR: begin
                w_mul_a = $signed(stap_pkg::MUL_A_BITS'(w_dep));
                w_mul_b = B_ONE - stap_pkg::MUL_B_BITS'(r_sine);
            end
            S_WL: begin
                w_mul_a = stap_pkg::MUL_A_BITS'(r_left);
                w_mul_b = $signed(stap_pkg::MUL_B_BITS'(r_gl));
            end
            S_WR: begin
                w_mul_a = stap_pkg::MUL_A_BITS'(r_right);
                w_mul_b = $signed(stap_pkg::MUL_B_BITS'(r_gr));
            end
            S_ML0: begin
                w_mul_a = stap_pkg::MUL_A_BITS'(r_left);
                w_mul_b = $signed(stap_pkg::MUL_B_BITS'(w_mix_c));
            end
            S_ML1: begin
                w_mul_a = stap_pkg::MUL_A_BITS'(r_wl);
                w_mul_b = $signed(stap_pkg::MUL_B_BITS'(w_mix));
            end
            S_MR0: begin
                w_mul_a = stap_pkg::MUL_A_BITS'(r_right);
                w_mul_b = $signed(stap_pkg::MUL_B_BITS'(w_mix_c));
            end
            // The wet right product is held while the result waits to be loaded.
            S_MR1, S_FIN: begin
                w_mul_a = stap_pkg::MUL_A_BITS'(r_wr);
                w_mul_b = $signed(stap_pkg::MUL_B_BITS'(w_mix));
            end
            default: begin
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    stap_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_m_valid    <= 1'b0;
            r_phase      <= '0;
            r_phase_step <= stap_pkg::STEP_BITS'(178957);
            r_depth      <= stap_pkg::CTRL_BITS'(16384);
            r_wet_mix    <= stap_pkg::CTRL_BITS'(32768);
            r_auto_pan   <= 1'b0;
        end else begin
            r_prod <= w_mul_p;
            if (r_state == S_FIN && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    stap_pkg::CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                    stap_pkg::CFG_DEPTH:      r_depth      <= i_cfg_data[stap_pkg::CTRL_BITS-1:0];
                    stap_pkg::CFG_WET_MIX:    r_wet_mix    <= i_cfg_data[stap_pkg::CTRL_BITS-1:0];
                    stap_pkg::CFG_AUTO_PAN:   r_auto_pan   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_left  <= i_s_axis_tdata[stap_pkg::SAMPLE_BITS-1:0];
                        r_right <= i_s_axis_tdata[2*stap_pkg::SAMPLE_BITS-1:stap_pkg::SAMPLE_BITS];
                        r_neg   <= w_turn[stap_pkg::TURN_BITS-1];
                        r_state <= S_DEN;
                    end
                end
                S_DEN: r_state <= S_DIV;
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_sine  <= r_neg ? -$signed({1'b0, w_div_rsp.quo})
                                         : $signed({1'b0, w_div_rsp.quo});
                        r_state <= S_GL;
                    end
                end
                S_GL: r_state <= S_GR;
                S_GR: begin
                    r_gl    <= w_gain;
                    r_state <= S_WL;
                end
                S_WL: begin
                    r_gr    <= r_auto_pan ? w_gain : r_gl;
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_wl    <= w_wet;
                    r_state <= S_ML0;
                end
                S_ML0: begin
                    r_wr    <= w_wet;
                    r_state <= S_ML1;
                end
                S_ML1: begin
                    r_acc   <= r_prod;
                    r_state <= S_MR0;
                end
                S_MR0: begin
                    r_mix_l <= w_mixed;
                    r_state <= S_MR1;
                end
                S_MR1: begin
                    r_acc   <= r_prod;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // The right channel is finished here from the held dry and wet products.
                    if (w_out_free) begin
                        r_out_l <= r_mix_l;
                        r_out_r <= w_mixed;
                        r_phase <= r_phase + stap_pkg::PHASE_BITS'(r_phase_step);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = stap_pkg::DATA_BITS'({r_out_r, r_out_l});

    `AST_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !o_s_axis_tready)
    `AST_HOLD(a_div_done_in_wait, i_clk, i_rst_n, !w_div_rsp.done || r_state == S_DIV)
    `AST_NEXT(a_result_loaded, i_clk, i_rst_n, r_state == S_FIN && w_out_free, o_m_axis_tvalid && o_s_axis_tready)

endmodule
